[rtl/sfbr_pkg.sv]
// Shared types and constants for the SPI flash boot-read emulator.
// No dependencies; every other file refers to this package by scoped names.
package sfbr_pkg;

  // Fixed field widths of the channels
  localparam int unsigned LoadAddrW = 13;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ErrW      = 2;

  // Widest image byte index (image of up to 64 KiB)
  localparam int unsigned MemAddrW  = 16;

  // Read command expected after reset
  localparam logic [ByteW-1:0] ReadOpcodeRst = 8'h03;

  // Operation queue depth
  localparam int unsigned QueueDepth = 2;

  // Item function codes
  typedef enum logic {
    FUNC_LOAD     = 1'b0,
    FUNC_EXCHANGE = 1'b1
  } func_e;

  // Sticky fault codes
  typedef enum logic [ErrW-1:0] {
    ERR_NONE    = 2'd0,
    ERR_COMMAND = 2'd1,
    ERR_ADDRESS = 2'd2
  } err_e;

  // Classified operation handed from the front end to the back end
  typedef struct packed {
    logic                wr;    // store data at addr
    logic                rd;    // send image byte at addr
    logic [MemAddrW-1:0] addr;
    logic [ByteW-1:0]    data;
    err_e                err;
    logic                done;
  } op_t;

endpackage

[rtl/sfbr_in_if.sv]
// Input channel of the boot-read emulator: valid/ready plus one item.
// Depends on sfbr_pkg for field widths.
interface sfbr_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [sfbr_pkg::LoadAddrW-1:0] load_addr;
  logic [sfbr_pkg::ByteW-1:0]     load_data;
  logic [sfbr_pkg::ByteW-1:0]     rx_byte;

  modport source (output valid, output func, output load_addr, output load_data,
                  output rx_byte, input ready);
  modport sink   (input valid, input func, input load_addr, input load_data,
                  input rx_byte, output ready);
endinterface

[rtl/sfbr_out_if.sv]
// Output channel of the boot-read emulator: valid/ready plus one result.
// Depends on sfbr_pkg for field widths.
interface sfbr_out_if;
  logic                       valid;
  logic                       ready;
  logic [sfbr_pkg::ByteW-1:0] tx_byte;
  logic [sfbr_pkg::ErrW-1:0]  error_kind;
  logic                       pass_done;

  modport source (output valid, output tx_byte, output error_kind, output pass_done,
                  input ready);
  modport sink   (input valid, input tx_byte, input error_kind, input pass_done,
                  output ready);
endinterface

[rtl/sfbr_front.sv]
// Front end: accepts items, tracks the read sequence, checks command and
// address, and emits one classified operation per item. Uses sfbr_pkg.
module sfbr_front #(
  parameter int unsigned IMAGE_BYTES  = 8192,
  parameter int unsigned HEADER_BYTES = 256,
  parameter int unsigned BLOCK_BYTES  = 2048,
  parameter int unsigned PAD_BYTES    = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sfbr_in_if.sink                    in_i,
  input  logic                       cfg_we_i,
  input  logic [sfbr_pkg::ByteW-1:0] cfg_wdata_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output sfbr_pkg::op_t              op_o
);

  localparam int unsigned NumBlocks = (IMAGE_BYTES + BLOCK_BYTES - 1) / BLOCK_BYTES;
  localparam int unsigned BlkW      = (NumBlocks > 1) ? $clog2(NumBlocks) : 1;
  localparam int unsigned LastLen   = IMAGE_BYTES - (NumBlocks - 1) * BLOCK_BYTES;
  localparam int unsigned SegMax    = PAD_BYTES +
                                      ((HEADER_BYTES > BLOCK_BYTES) ? HEADER_BYTES
                                                                    : BLOCK_BYTES);
  localparam int unsigned PosW      = $clog2(SegMax + 1);
  localparam int unsigned ImgAW     = $clog2(IMAGE_BYTES);
  localparam int unsigned SumW      = sfbr_pkg::MemAddrW + 1;

  logic [sfbr_pkg::ByteW-1:0] opcode_q;
  logic [PosW-1:0]            pos_q, pos_d;
  logic [BlkW-1:0]            blk_q, blk_d;
  logic [ImgAW-1:0]           base_q, base_d;
  logic [15:0]                acc_q, acc_d;
  sfbr_pkg::err_e             fault_q, fault_d;
  logic                       hdr_q, hdr_d;

  logic            accept;
  logic            is_xchg;
  logic            last_blk;
  logic [PosW-1:0] seg_end;
  logic            at_end;
  logic            is_pad;
  logic            check;
  logic [PosW-1:0] offset;
  logic [SumW-1:0] mem_sum;
  logic [SumW-1:0] next_base;
  logic            done;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign push_o     = accept;
  assign is_xchg    = (in_i.func == sfbr_pkg::FUNC_EXCHANGE);

  // Segment geometry
  assign last_blk = (blk_q == BlkW'(NumBlocks - 1));
  always_comb begin
    if (hdr_q) begin
      seg_end = PosW'(PAD_BYTES + HEADER_BYTES - 1);
    end else if (last_blk) begin
      seg_end = PosW'(PAD_BYTES + LastLen - 1);
    end else begin
      seg_end = PosW'(PAD_BYTES + BLOCK_BYTES - 1);
    end
  end
  assign at_end    = (pos_q == seg_end);
  assign is_pad    = (pos_q < PosW'(PAD_BYTES));
  assign offset    = pos_q - PosW'(PAD_BYTES);
  assign mem_sum   = SumW'(base_q) + SumW'(offset);
  assign next_base = SumW'(base_q) + SumW'(BLOCK_BYTES);
  assign check     = !hdr_q && (fault_q == sfbr_pkg::ERR_NONE);

  // Sequence advance and command/address check
  always_comb begin
    pos_d   = pos_q;
    blk_d   = blk_q;
    base_d  = base_q;
    acc_d   = acc_q;
    fault_d = fault_q;
    hdr_d   = hdr_q;
    done    = 1'b0;
    if (accept && is_xchg) begin
      if (check) begin
        if (pos_q == PosW'(0)) begin
          acc_d = '0;
          if (in_i.rx_byte != opcode_q) begin
            fault_d = sfbr_pkg::ERR_COMMAND;
          end
        end else if (pos_q == PosW'(1) || pos_q == PosW'(2)) begin
          acc_d = {acc_q[7:0], in_i.rx_byte};
        end else if (pos_q == PosW'(3)) begin
          acc_d = {acc_q[7:0], in_i.rx_byte};
          if ({acc_q, in_i.rx_byte} != 24'(base_q)) begin
            fault_d = sfbr_pkg::ERR_ADDRESS;
          end
        end
      end
      if (at_end) begin
        pos_d = '0;
        if (hdr_q) begin
          hdr_d  = 1'b0;
          blk_d  = '0;
          base_d = '0;
        end else if (last_blk) begin
          done   = 1'b1;
          hdr_d  = 1'b1;
          blk_d  = '0;
          base_d = '0;
        end else begin
          blk_d  = blk_q + BlkW'(1);
          base_d = ImgAW'(next_base);
        end
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Build the operation for the back end
  always_comb begin
    op_o.data = in_i.load_data;
    op_o.err  = fault_d;
    if (is_xchg) begin
      op_o.wr   = 1'b0;
      op_o.rd   = !is_pad && (fault_d == sfbr_pkg::ERR_NONE);
      op_o.addr = sfbr_pkg::MemAddrW'(mem_sum);
      op_o.done = done && (fault_d == sfbr_pkg::ERR_NONE);
    end else begin
      op_o.wr   = (SumW'(in_i.load_addr) < SumW'(IMAGE_BYTES));
      op_o.rd   = 1'b0;
      op_o.addr = sfbr_pkg::MemAddrW'(in_i.load_addr);
      op_o.done = 1'b0;
    end
  end

  // Hold sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      blk_q   <= '0;
      base_q  <= '0;
      acc_q   <= '0;
      fault_q <= sfbr_pkg::ERR_NONE;
      hdr_q   <= 1'b1;
    end else begin
      pos_q   <= pos_d;
      blk_q   <= blk_d;
      base_q  <= base_d;
      acc_q   <= acc_d;
      fault_q <= fault_d;
      hdr_q   <= hdr_d;
    end
  end

  // Command register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opcode_q <= sfbr_pkg::ReadOpcodeRst;
    end else if (cfg_we_i) begin
      opcode_q <= cfg_wdata_i;
    end
  end

endmodule

[rtl/sfbr_queue.sv]
// Short operation queue between front and back end.
// Uses sfbr_pkg for the operation type and depth.
module sfbr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sfbr_pkg::op_t op_i,
  input  logic          pop_i,
  output sfbr_pkg::op_t op_o,
  output logic          full_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(sfbr_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(sfbr_pkg::QueueDepth + 1);

  sfbr_pkg::op_t   slot_q [sfbr_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(sfbr_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign op_o    = slot_q[rd_ptr_q];

  // Store pushed operations
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= op_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(sfbr_pkg::QueueDepth - 1)) ? '0
                                                                   : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(sfbr_pkg::QueueDepth - 1)) ? '0
                                                                   : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/sfbr_back.sv]
// Back end: carries out loads and image reads on the image memory and
// holds the result word in the output register. Uses sfbr_pkg.
module sfbr_back #(
  parameter int unsigned IMAGE_BYTES = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfbr_pkg::op_t op_i,
  input  logic          empty_i,
  output logic          pop_o,
  sfbr_out_if.source    out_o
);

  localparam int unsigned ImgAW = $clog2(IMAGE_BYTES);

  logic [sfbr_pkg::ByteW-1:0] mem_q [IMAGE_BYTES];
  logic [sfbr_pkg::ByteW-1:0] rd_data_q;
  logic                       valid_q;
  logic                       rd_q;
  sfbr_pkg::err_e             err_q;
  logic                       done_q;
  logic [ImgAW-1:0]           addr;

  assign pop_o = !empty_i && (!valid_q || out_o.ready);
  assign addr  = op_i.addr[ImgAW-1:0];

  // Image memory: one write or one read per popped operation
  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.wr) begin
      mem_q[addr] <= op_i.data;
    end
    if (pop_o && op_i.rd) begin
      rd_data_q <= mem_q[addr];
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_q   <= op_i.rd;
      err_q  <= op_i.err;
      done_q <= op_i.done;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.tx_byte    = rd_q ? rd_data_q : '0;
  assign out_o.error_kind = err_q;
  assign out_o.pass_done  = done_q;

endmodule

[rtl/spi_flash_boot_read_emulator_unit.sv]
// Top level of the SPI flash boot-read emulator.
// Depends on sfbr_pkg, sfbr_in_if, sfbr_out_if, sfbr_front, sfbr_queue, sfbr_back.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   func, load_addr, load_data, rx_byte
//   out_o    out  valid/ready   tx_byte, error_kind, pass_done
//   cfg      in   cfg_we_i      cfg_wdata_i (read_opcode)
//
// One word in and one word out per cycle when neither side stalls; a result
// leaves once its item has passed the operation queue and the registered
// image memory read. A two-entry queue lets the front end keep taking words,
// until it fills, while the output is stalled. Reset clears the sequence
// state and fault code, resets the read opcode; the image memory is not cleared.
module spi_flash_boot_read_emulator_unit #(
  parameter int unsigned IMAGE_BYTES  = 8192,
  parameter int unsigned HEADER_BYTES = 256,
  parameter int unsigned BLOCK_BYTES  = 2048,
  parameter int unsigned PAD_BYTES    = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sfbr_in_if.sink                    in_i,
  sfbr_out_if.source                 out_o,
  input  logic                       cfg_we_i,
  input  logic [sfbr_pkg::ByteW-1:0] cfg_wdata_i
);

  sfbr_pkg::op_t push_op;
  sfbr_pkg::op_t head_op;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  // Classify items
  sfbr_front #(
    .IMAGE_BYTES  (IMAGE_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .PAD_BYTES    (PAD_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .op_o        (push_op)
  );

  // Decouple front and back
  sfbr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .op_o    (head_op),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Execute on the image memory
  sfbr_back #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (head_op),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
